### sv/pfu_pkg.sv
package pfu_pkg;

  // Field widths
  localparam int unsigned PosW   = 24;
  localparam int unsigned RampW  = 15;
  localparam int unsigned ColW   = 8;
  localparam int unsigned AlphaW = 9;
  localparam int unsigned DieW   = 32;
  localparam int unsigned FtW    = 16;
  localparam int unsigned NowW   = 31;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Ramp ends in Q3.12, as 17-bit sums
  localparam logic [16:0] FireEnd  = 17'd24576;
  localparam logic [16:0] ExplEnd  = 17'd32768;
  localparam logic [14:0] RampMax  = 15'h7fff;

  // Particle kinds
  typedef enum logic [2:0] {
    KIND_STATIC   = 3'd0,
    KIND_GRAV     = 3'd1,
    KIND_SLOWGRAV = 3'd2,
    KIND_FIRE     = 3'd3,
    KIND_EXPLODE  = 3'd4,
    KIND_EXPLODE2 = 3'd5,
    KIND_BLOB     = 3'd6,
    KIND_BLOB2    = 3'd7
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_TIME = 2'd0,
    CFG_NOW_MS     = 2'd1,
    CFG_PAUSED     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [PosW-1:0]   pos_x;
    logic signed [PosW-1:0]   pos_y;
    logic signed [PosW-1:0]   pos_z;
    logic signed [PosW-1:0]   speed_x;
    logic signed [PosW-1:0]   speed_y;
    logic signed [PosW-1:0]   speed_z;
    logic        [RampW-1:0]  ramp_pos;
    logic        [2:0]        kind;
    logic        [ColW-1:0]   colour_in;
    logic        [AlphaW-1:0] alpha_in;
    logic signed [DieW-1:0]   die_ms;
  } item_t;

  typedef struct packed {
    logic signed [PosW-1:0]   new_pos_x;
    logic signed [PosW-1:0]   new_pos_y;
    logic signed [PosW-1:0]   new_pos_z;
    logic signed [PosW-1:0]   new_speed_x;
    logic signed [PosW-1:0]   new_speed_y;
    logic signed [PosW-1:0]   new_speed_z;
    logic        [RampW-1:0]  new_ramp_pos;
    logic        [ColW-1:0]   colour_out;
    logic        [AlphaW-1:0] alpha_out;
    logic signed [DieW-1:0]   new_die_ms;
    logic                     removed;
  } result_t;

  // Saturate a 28-bit signed sum to Q15.8
  function automatic logic signed [PosW-1:0] sat24(input logic signed [27:0] v);
    logic signed [27:0] hi;
    logic signed [27:0] lo;
    hi = 28'sd8388607;
    lo = -28'sd8388608;
    if (v > hi) begin
      sat24 = 24'sh7fffff;
    end else if (v < lo) begin
      sat24 = 24'sh800000;
    end else begin
      sat24 = v[PosW-1:0];
    end
  endfunction

  // Colour ramps
  function automatic logic [ColW-1:0] fire_colour(input logic [2:0] idx);
    case (idx)
      3'd0:    fire_colour = 8'h6d;
      3'd1:    fire_colour = 8'h6b;
      3'd2:    fire_colour = 8'h06;
      3'd3:    fire_colour = 8'h05;
      3'd4:    fire_colour = 8'h04;
      3'd5:    fire_colour = 8'h03;
      default: fire_colour = 8'h00;
    endcase
  endfunction

  function automatic logic [ColW-1:0] expl_colour(input logic [2:0] idx);
    case (idx)
      3'd0:    expl_colour = 8'h6f;
      3'd1:    expl_colour = 8'h6d;
      3'd2:    expl_colour = 8'h6b;
      3'd3:    expl_colour = 8'h69;
      3'd4:    expl_colour = 8'h67;
      3'd5:    expl_colour = 8'h65;
      3'd6:    expl_colour = 8'h63;
      default: expl_colour = 8'h61;
    endcase
  endfunction

  function automatic logic [ColW-1:0] expl2_colour(input logic [2:0] idx);
    case (idx)
      3'd0:    expl2_colour = 8'h6f;
      3'd1:    expl2_colour = 8'h6e;
      3'd2:    expl2_colour = 8'h6d;
      3'd3:    expl2_colour = 8'h6c;
      3'd4:    expl2_colour = 8'h6b;
      3'd5:    expl2_colour = 8'h6a;
      3'd6:    expl2_colour = 8'h68;
      default: expl2_colour = 8'h66;
    endcase
  endfunction

endpackage

### sv/pfu_if.sv
// Particle record channel
interface pfu_item_if;
  import pfu_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Updated record channel
interface pfu_result_if;
  import pfu_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Register write channel
interface pfu_cfg_if;
  import pfu_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  idx;
  logic [CfgDataW-1:0] wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

### sv/particle_frame_update.sv
// Particle frame update.
// item_i takes one particle record per word; result_o gives the record for
// the next frame, one word per item, in order. cfg_i writes frame_time (0),
// now_ms (1) and paused (2); it is always ready. It must be written only
// while no item is in flight; the block itself does not enforce this.
// An accepted item passes through an input register, then the result
// register, to its result word. Throughput: one item per cycle while
// result_o.ready stays high; the path between the two registers is one
// 24x16 multiply per axis followed by an add and saturation.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more item; item_i.ready falls only when both are
// full. Reset empties both stages and zeroes the configuration registers.
// Expired particles (die time before now) come back unchanged with removed
// set; in paused mode live particles come back unchanged.
module particle_frame_update (
  input  logic clk_i,
  input  logic rst_ni,
  pfu_item_if.sink     item_i,
  pfu_result_if.source result_o,
  pfu_cfg_if.sink      cfg_i
);
  import pfu_pkg::*;

  // Configuration registers
  logic [FtW-1:0]  frame_time_q;
  logic [NowW-1:0] now_ms_q;
  logic            paused_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_time_q <= '0;
      now_ms_q     <= '0;
      paused_q     <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.idx))
        CFG_FRAME_TIME: frame_time_q <= cfg_i.wdata[FtW-1:0];
        CFG_NOW_MS:     now_ms_q     <= cfg_i.wdata[NowW-1:0];
        CFG_PAUSED:     paused_q     <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake between the two stages
  logic    s1_valid_q;
  item_t   s1_q;
  logic    res_valid_q;
  result_t res_q;
  logic    s2_ready;
  logic    s1_adv;

  assign s2_ready     = !res_valid_q || result_o.ready;
  assign s1_adv       = s1_valid_q && s2_ready;
  assign item_i.ready = !s1_valid_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (item_i.ready) begin
        s1_valid_q <= item_i.valid;
      end
      if (s2_ready) begin
        res_valid_q <= s1_valid_q;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      s1_q <= item_i.data;
    end
  end

  // Per-axis products speed * frame_time
  logic signed [PosW-1:0] pos_in [3];
  logic signed [PosW-1:0] vel_in [3];
  logic signed [40:0]     prod   [3];
  logic signed [25:0]     pos_sum [3];
  logic signed [27:0]     vel_sum [3];
  logic signed [27:0]     dvel    [3];
  logic signed [PosW-1:0] pos_new [3];
  logic signed [PosW-1:0] vel_new [3];
  logic signed [40:0]     ft_s;

  assign pos_in[0] = s1_q.pos_x;
  assign pos_in[1] = s1_q.pos_y;
  assign pos_in[2] = s1_q.pos_z;
  assign vel_in[0] = s1_q.speed_x;
  assign vel_in[1] = s1_q.speed_y;
  assign vel_in[2] = s1_q.speed_z;
  assign ft_s      = 41'($signed({1'b0, frame_time_q}));

  kind_e kind;
  assign kind = kind_e'(s1_q.kind);

  // Gravity: floor(40 * ft / 256)
  logic [21:0] grav_full;
  logic [13:0] grav;
  assign grav_full = 22'(frame_time_q) * 22'd40;
  assign grav      = grav_full[21:8];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a]    = 41'(vel_in[a]) * ft_s;
      pos_sum[a] = 26'(pos_in[a]) + 26'(prod[a] >>> 16);
      pos_new[a] = sat24(28'(pos_sum[a]));
      // velocity growth or damping
      case (kind) inside
        KIND_EXPLODE, KIND_BLOB: dvel[a] = 28'(prod[a] >>> 14);
        KIND_EXPLODE2:           dvel[a] = -28'(prod[a] >>> 16);
        KIND_BLOB2:              dvel[a] = (a < 2) ? -28'(prod[a] >>> 14) : '0;
        default:                 dvel[a] = '0;
      endcase
      vel_sum[a] = 28'(vel_in[a]) + dvel[a];
    end
    // gravity on z: fire rises, static stays, the rest fall
    if (kind == KIND_FIRE) begin
      vel_sum[2] = vel_sum[2] + 28'(grav);
    end else if (kind != KIND_STATIC) begin
      vel_sum[2] = vel_sum[2] - 28'(grav);
    end
    for (int a = 0; a < 3; a++) begin
      vel_new[a] = sat24(vel_sum[a]);
    end
  end

  // Colour ramp
  logic [19:0] step_full;
  logic [16:0] ramp_sum;
  logic [16:0] ramp_end;
  logic        has_ramp;
  logic        ramp_done;
  logic [2:0]  ramp_idx;
  logic [ColW-1:0] ramp_colour;

  always_comb begin
    has_ramp = 1'b1;
    ramp_end = ExplEnd;
    case (kind)
      KIND_FIRE: begin
        step_full = 20'(frame_time_q) * 20'd5;
        ramp_end  = FireEnd;
      end
      KIND_EXPLODE:  step_full = 20'(frame_time_q) * 20'd10;
      KIND_EXPLODE2: step_full = 20'(frame_time_q) * 20'd15;
      default: begin
        step_full = '0;
        has_ramp  = 1'b0;
      end
    endcase
    ramp_sum  = 17'(s1_q.ramp_pos) + 17'(step_full[19:4]);
    ramp_done = (ramp_sum >= ramp_end);
    ramp_idx  = ramp_sum[14:12];
    case (kind)
      KIND_FIRE:    ramp_colour = fire_colour(ramp_idx);
      KIND_EXPLODE: ramp_colour = expl_colour(ramp_idx);
      default:      ramp_colour = expl2_colour(ramp_idx);
    endcase
  end

  // Fire alpha: floor((24576 - ramp) / 96) as (rem >> 5) * 683 >> 11
  logic [14:0] fire_rem;
  logic [19:0] alpha_prod;
  logic [AlphaW-1:0] fire_alpha;
  assign fire_rem   = (ramp_sum < FireEnd) ? 15'(FireEnd - ramp_sum) : '0;
  assign alpha_prod = 20'(fire_rem[14:5]) * 20'd683;
  assign fire_alpha = alpha_prod[19:11];

  // Removal test against now
  logic expired;
  assign expired = ($signed({s1_q.die_ms[DieW-1], s1_q.die_ms}) <
                    $signed({2'b00, now_ms_q}));

  // Result assembly
  result_t res_d;
  always_comb begin
    res_d.new_pos_x    = s1_q.pos_x;
    res_d.new_pos_y    = s1_q.pos_y;
    res_d.new_pos_z    = s1_q.pos_z;
    res_d.new_speed_x  = s1_q.speed_x;
    res_d.new_speed_y  = s1_q.speed_y;
    res_d.new_speed_z  = s1_q.speed_z;
    res_d.new_ramp_pos = s1_q.ramp_pos;
    res_d.colour_out   = s1_q.colour_in;
    res_d.alpha_out    = s1_q.alpha_in;
    res_d.new_die_ms   = s1_q.die_ms;
    res_d.removed      = expired;
    if (!expired && !paused_q) begin
      res_d.new_pos_x   = pos_new[0];
      res_d.new_pos_y   = pos_new[1];
      res_d.new_pos_z   = pos_new[2];
      res_d.new_speed_x = vel_new[0];
      res_d.new_speed_y = vel_new[1];
      res_d.new_speed_z = vel_new[2];
      if (has_ramp) begin
        // saturate anything at or above 8.0
        res_d.new_ramp_pos = (|ramp_sum[16:15]) ? RampMax : ramp_sum[14:0];
        if (ramp_done) begin
          res_d.new_die_ms = -32'sd1;
        end else begin
          res_d.colour_out = ramp_colour;
        end
        if (kind == KIND_FIRE) begin
          res_d.alpha_out = fire_alpha;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

`ifndef SYNTH
  // an accepted word always lands in the input stage
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> s1_valid_q)
    else $error("accepted word not captured in input stage");

  // a word held in the input stage is not dropped while the output stalls
  a_hold_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q)
    else $error("input stage word lost during stall");

  // backpressure only when the input stage is occupied
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> s1_valid_q && res_valid_q)
    else $error("ready low with a free stage");
`endif

endmodule
